[src/lkv_pkg.sv]
package lkv_pkg;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic found;
    logic install;
    logic evict;
  } lkv_dec_t;

endpackage

[src/lkv_req_if.sv]
interface lkv_req_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [KEY_BITS-1:0]   lookup_key;
  logic signed [VALUE_BITS-1:0] write_value;

  modport source (output valid, req_type, lookup_key, write_value, input ready);
  modport sink   (input valid, req_type, lookup_key, write_value, output ready);
endinterface

[src/lkv_rsp_if.sv]
interface lkv_rsp_if #(
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         evicted;

  modport source (output valid, found, read_value, evicted, input ready);
  modport sink   (input valid, found, read_value, evicted, output ready);
endinterface

[src/lkv_cfg_if.sv]
interface lkv_cfg_if ();
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

[src/lkv_match.sv]
module lkv_match #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned AGE_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                               put_i,
  input  logic [KEY_BITS-1:0]                key_i,
  input  logic [lkv_pkg::CAP_W-1:0]          cap_i,
  input  logic [SLOTS-1:0]                   slot_valid_i,
  input  logic [SLOTS-1:0][KEY_BITS-1:0]     slot_key_i,
  input  logic [SLOTS-1:0][AGE_W-1:0]        slot_age_i,
  input  logic [CNT_W-1:0]                   fill_i,
  output logic [SLOTS-1:0]                   hit_oh_o,
  output logic [SLOTS-1:0]                   tgt_oh_o,
  output lkv_pkg::lkv_dec_t                  dec_o
);
  import lkv_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [CNT_W-1:0] fill_m1;
  logic [SLOTS-1:0] free;
  logic [SLOTS-1:0] free_first;
  logic [SLOTS-1:0] victim_oh;
  logic             use_free;
  logic             found;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_oh_o[i] = slot_valid_i[i] && (slot_key_i[i] == key_i);
    end
  end

  assign found = |hit_oh_o;

  // lowest free slot
  assign free       = ~slot_valid_i;
  assign free_first = free & (~free + SLOTS'(1));

  // oldest valid slot holds rank fill-1
  assign fill_m1 = fill_i - CNT_W'(1);
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      victim_oh[i] = slot_valid_i[i] && (slot_age_i[i] == fill_m1[AGE_W-1:0]);
    end
  end

  assign cap_ext = CMP_W'(cap_i);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(SLOTS)) begin
      eff_cap = CMP_W'(SLOTS);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign use_free = (CMP_W'(fill_i) < eff_cap) && (|free);

  assign tgt_oh_o      = use_free ? free_first : victim_oh;
  assign dec_o.found   = found;
  assign dec_o.install = put_i && !found;
  assign dec_o.evict   = put_i && !found && !use_free;

endmodule

[src/lkv_store.sv]
module lkv_store #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned AGE_W      = 4,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                upd_i,
  input  logic                                put_i,
  input  logic [KEY_BITS-1:0]                 key_i,
  input  logic [VALUE_BITS-1:0]               value_i,
  input  logic [SLOTS-1:0]                    hit_oh_i,
  input  logic [SLOTS-1:0]                    tgt_oh_i,
  input  lkv_pkg::lkv_dec_t                   dec_i,
  output logic [SLOTS-1:0]                    slot_valid_o,
  output logic [SLOTS-1:0][KEY_BITS-1:0]      slot_key_o,
  output logic [SLOTS-1:0][AGE_W-1:0]         slot_age_o,
  output logic [CNT_W-1:0]                    fill_o,
  output logic [VALUE_BITS-1:0]               hit_value_o
);
  import lkv_pkg::*;

  logic [SLOTS-1:0]                 valid_q, valid_d;
  logic [SLOTS-1:0][AGE_W-1:0]      age_q, age_d;
  logic [SLOTS-1:0][KEY_BITS-1:0]   key_q;
  logic [SLOTS-1:0][VALUE_BITS-1:0] value_q;
  logic [CNT_W-1:0]                 fill_q, fill_d;
  logic [AGE_W-1:0]                 hit_age;

  always_comb begin
    hit_age     = '0;
    hit_value_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_oh_i[i]) begin
        hit_age     = hit_age | age_q[i];
        hit_value_o = hit_value_o | value_q[i];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    fill_d  = fill_q;
    if (upd_i) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (dec_i.found) begin
          if (hit_oh_i[i]) begin
            age_d[i] = '0;
          end else if (valid_q[i] && (age_q[i] < hit_age)) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end else if (dec_i.install) begin
          if (tgt_oh_i[i]) begin
            valid_d[i] = 1'b1;
            age_d[i]   = '0;
          end else if (valid_q[i]) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
      end
      if (dec_i.install && !dec_i.evict) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '0;
      fill_q  <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (upd_i && dec_i.install && tgt_oh_i[i]) begin
        key_q[i]   <= key_i;
        value_q[i] <= value_i;
      end else if (upd_i && put_i && hit_oh_i[i]) begin
        value_q[i] <= value_i;
      end
    end
  end

  assign slot_valid_o = valid_q;
  assign slot_key_o   = key_q;
  assign slot_age_o   = age_q;
  assign fill_o       = fill_q;

endmodule

[src/lru_key_value_cache_unit.sv]
// Fully associative key-value cache with least-recently-used replacement. Each
// request beat is a get or a put; every request yields exactly one response beat,
// in order. Requests are taken one per cycle unless a stalled response holds the
// input register: a beat lands there, is matched against all SLOTS entries and
// updates the recency ranks together, and is answered from the output register.
// The one-cycle rate is set by the parallel key compare and rank update over all
// slots. A get that hits returns the value and makes the entry most recent; a
// miss returns all ones with found low. A put returns zero, sets found if the key
// was present and evicted if the least recent entry was replaced. capacity_in_use
// (0 acts as 1, values above SLOTS saturate) should only be written while idle.
module lru_key_value_cache_unit #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkv_req_if.sink    req_i,
  lkv_rsp_if.source  rsp_o,
  lkv_cfg_if.sink    cfg_i
);
  import lkv_pkg::*;

  localparam int unsigned AGE_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  logic [CAP_W-1:0]      cap_q;

  logic                  in_vld_q, in_vld_d;
  logic                  put_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wval_q;

  logic                  out_vld_q, out_vld_d;
  logic                  found_q;
  logic [VALUE_BITS-1:0] rval_q, rval_d;
  logic                  evict_q;

  logic                  proc;
  logic                  req_acc;

  logic [SLOTS-1:0]                 slot_valid;
  logic [SLOTS-1:0][KEY_BITS-1:0]   slot_key;
  logic [SLOTS-1:0][AGE_W-1:0]      slot_age;
  logic [CNT_W-1:0]                 fill;
  logic [SLOTS-1:0]                 hit_oh;
  logic [SLOTS-1:0]                 tgt_oh;
  lkv_dec_t                         dec;
  logic [VALUE_BITS-1:0]            hit_value;

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.capacity_in_use;
    end
  end

  // handshake
  assign proc        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || proc;
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (proc) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      put_q  <= (req_i.req_type == REQ_PUT);
      key_q  <= req_i.lookup_key;
      wval_q <= req_i.write_value;
    end
  end

  lkv_match #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS),
    .AGE_W    (AGE_W),
    .CNT_W    (CNT_W)
  ) u_match (
    .put_i        (put_q),
    .key_i        (key_q),
    .cap_i        (cap_q),
    .slot_valid_i (slot_valid),
    .slot_key_i   (slot_key),
    .slot_age_i   (slot_age),
    .fill_i       (fill),
    .hit_oh_o     (hit_oh),
    .tgt_oh_o     (tgt_oh),
    .dec_o        (dec)
  );

  lkv_store #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .AGE_W      (AGE_W),
    .CNT_W      (CNT_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (proc),
    .put_i        (put_q),
    .key_i        (key_q),
    .value_i      (wval_q),
    .hit_oh_i     (hit_oh),
    .tgt_oh_i     (tgt_oh),
    .dec_i        (dec),
    .slot_valid_o (slot_valid),
    .slot_key_o   (slot_key),
    .slot_age_o   (slot_age),
    .fill_o       (fill),
    .hit_value_o  (hit_value)
  );

  always_comb begin
    if (put_q) begin
      rval_d = '0;
    end else if (dec.found) begin
      rval_d = hit_value;
    end else begin
      rval_d = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      found_q <= dec.found;
      rval_q  <= rval_d;
      evict_q <= dec.evict;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.read_value = rval_q;
  assign rsp_o.evicted    = evict_q;

endmodule
